[design/mmscl_pkg.sv]
// ----------------------------------------------------------------------------
// mmscl_pkg
// Shared widths, constants, request codes and the controller/datapath
// command and status bundles of the two-axis calibrated scaler.
// ----------------------------------------------------------------------------
package mmscl_pkg;

    // measurement samples averaged per result (1..16)
    localparam int AVG_SAMPLES = 4;

    // field widths
    localparam int SMP_W   = 12;
    localparam int SUM_W   = 16;
    localparam int TALLY_W = 4;
    localparam int HALF_W  = 11;
    localparam int POS_W   = 10;
    localparam int PROD_W  = 2 * SMP_W;
    localparam int CNT_W   = 4;

    // mean by reciprocal multiply: exact floor for any 16-bit sum and a
    // divisor up to 16, since sum * rounding error stays below 2^MEAN_K
    localparam int MEAN_K      = SUM_W + 5;
    localparam int MEAN_PROD_W = SUM_W + MEAN_K + 1;

    // arithmetic constants
    localparam logic [SMP_W-1:0]   FULL12     = 12'hFFF;
    localparam logic [SMP_W:0]     CENTER     = 13'd2048;
    localparam logic [HALF_W-1:0]  HALF_RESET = 11'd1500;
    localparam logic [TALLY_W:0]   AVG_CNT    = (TALLY_W + 1)'(AVG_SAMPLES);
    localparam logic [MEAN_K:0]    MEAN_RECIP =
        (MEAN_K + 1)'(((1 << MEAN_K) + AVG_SAMPLES - 1) / AVG_SAMPLES);

    // one quotient bit per step, 12-bit quotients
    localparam logic [CNT_W-1:0]   DIV_STEPS  = CNT_W'(SMP_W);

    // request codes
    typedef logic [1:0] t_req;
    localparam t_req REQ_START = 2'd0;
    localparam t_req REQ_CALIB = 2'd1;
    localparam t_req REQ_MEAS  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clear_all;     // start request: reset bounds and accumulators
        logic calib_upd;     // widen min/max of the addressed channel
        logic meas_add;      // accumulate a measurement sample
        logic sum_load;      // last sample: latch channel and closing sum
        logic mean_calc;     // scale the closing sum down to the mean
        logic div_step;      // one restoring division step
        logic prep;          // latch mean, select bounds, clamp
        logic mul;           // scale offset, load divider for the mapping
        logic out_load;      // move the finished result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_sample;   // this measurement completes the average
        logic out_free;      // output register can take a result this cycle
    } t_dp_stat;

endpackage

[design/mmscl_ctrl.sv]
// ----------------------------------------------------------------------------
// mmscl_ctrl
// Sequencer: accepts request beats, steps the mean, bound selection and the
// mapping division and hands the result to the output register.
// ----------------------------------------------------------------------------
module mmscl_ctrl
    import mmscl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_req     i_req_type,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_PREP,
        S_MUL,
        S_MAP_DIV,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    // input beat taken only when idle
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = (r_state == S_IDLE) && i_valid;

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_START: o_cmd.clear_all = 1'b1;
                        REQ_CALIB: o_cmd.calib_upd = 1'b1;
                        REQ_MEAS: begin
                            o_cmd.meas_add = 1'b1;
                            if (i_stat.last_sample) begin
                                o_cmd.sum_load = 1'b1;
                                n_state = S_MEAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MEAN: begin
                o_cmd.mean_calc = 1'b1;
                n_state         = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MAP_DIV;
                n_cnt     = '0;
            end
            S_MAP_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_STEPS - 1'b1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // step counter never runs past the quotient width
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP_DIV) |-> (r_cnt < DIV_STEPS))
        else $error("division step counter out of range");

    // mean cycle hands over to bound selection
    a_mean_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEAN) |=> (r_state == S_PREP))
        else $error("mean cycle did not hand over to bound selection");

    // a delivered result frees the sequencer for the next beat
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_stall)
        else $error("sequencer busy after result load");

endmodule

[design/mmscl_dp.sv]
// ----------------------------------------------------------------------------
// mmscl_dp
// Datapath: per-channel bounds and accumulators, reciprocal-multiply mean,
// fallback bound selection, clamp, offset scaling, a radix-2 restoring
// divider for the mapping and the output register.
// ----------------------------------------------------------------------------
module mmscl_dp
    import mmscl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_channel,
    input  logic [SMP_W-1:0]  i_sample,
    input  logic              i_cfg_we,
    input  logic [HALF_W-1:0] i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_axis,
    output logic [POS_W-1:0]  o_position,
    output logic [SMP_W-1:0]  o_mean_raw,
    output logic              o_fallback_used
);

    // calibration and accumulation state
    logic [SMP_W-1:0]   r_low   [2];
    logic [SMP_W-1:0]   r_high  [2];
    logic [SUM_W-1:0]   r_sum   [2];
    logic [TALLY_W-1:0] r_tally [2];
    logic [HALF_W-1:0]  r_half;
    logic               r_ovalid;

    // working registers of one averaged result
    logic               r_ch;
    logic [SUM_W-1:0]   r_acc;
    logic [SMP_W-1:0]   r_rem, r_nq, r_den;
    logic [SMP_W-1:0]   r_mean, r_x, r_lo, r_hi;
    logic               r_fb, r_zero, r_full;

    // output register
    logic               r_o_axis, r_o_fb;
    logic [POS_W-1:0]   r_o_pos;
    logic [SMP_W-1:0]   r_o_mean;

    logic [SUM_W-1:0]       w_sum_new;
    logic [TALLY_W:0]       w_tally_inc;
    logic [MEAN_PROD_W-1:0] w_mean_prod;
    logic [SMP_W:0]         w_trial, w_sub;
    logic                   w_ge;
    logic [SMP_W-1:0]       w_cal_lo, w_cal_hi, w_lo, w_hi, w_x;
    logic [SMP_W:0]         w_fb_lo, w_fb_hi;
    logic                   w_fb;
    logic [SMP_W-1:0]       w_diff;
    logic [PROD_W-1:0]      w_prod;
    logic [SMP_W-1:0]       w_map;

    // accumulate and detect the closing sample of an average
    assign w_sum_new   = r_sum[i_channel] + SUM_W'(i_sample);
    assign w_tally_inc = {1'b0, r_tally[i_channel]} + 1'b1;

    assign o_stat.last_sample = (w_tally_inc >= AVG_CNT);
    assign o_stat.out_free    = !r_ovalid || !i_stall;

    // closing sum times the rounded-up reciprocal of the average length
    assign w_mean_prod = MEAN_PROD_W'(r_acc) * MEAN_PROD_W'(MEAN_RECIP);

    // one restoring division step
    assign w_trial = {r_rem, r_nq[SMP_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // bound selection with fallback around the center
    always_comb begin
        w_cal_lo = r_low[r_ch];
        w_cal_hi = r_high[r_ch];
        w_fb     = (w_cal_lo >= w_cal_hi);
        w_fb_lo  = (CENTER > {2'b0, r_half}) ? (CENTER - {2'b0, r_half}) : '0;
        w_fb_hi  = CENTER + {2'b0, r_half};
        if (w_fb_hi > {1'b0, FULL12}) begin
            w_fb_hi = {1'b0, FULL12};
        end
        w_lo = w_fb ? w_fb_lo[SMP_W-1:0] : w_cal_lo;
        w_hi = w_fb ? w_fb_hi[SMP_W-1:0] : w_cal_hi;
        // clamp the mean into the range
        w_x = r_nq;
        if (w_x < w_lo) begin
            w_x = w_lo;
        end
        if (w_x > w_hi) begin
            w_x = w_hi;
        end
    end

    // offset scaled onto the full 12-bit span
    assign w_diff = r_x - r_lo;
    assign w_prod = PROD_W'(w_diff) * PROD_W'(FULL12);

    // mapped value with its edge cases
    assign w_map = r_zero ? '0 : (r_full ? FULL12 : r_nq);

    // bounds, accumulators, config and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_low[c]   <= FULL12;
                r_high[c]  <= '0;
                r_sum[c]   <= '0;
                r_tally[c] <= '0;
            end
            r_half   <= HALF_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_data;
            end
            if (i_cmd.clear_all) begin
                for (int c = 0; c < 2; c++) begin
                    r_low[c]   <= FULL12;
                    r_high[c]  <= '0;
                    r_sum[c]   <= '0;
                    r_tally[c] <= '0;
                end
            end
            if (i_cmd.calib_upd) begin
                if (i_sample < r_low[i_channel]) begin
                    r_low[i_channel] <= i_sample;
                end
                if (i_sample > r_high[i_channel]) begin
                    r_high[i_channel] <= i_sample;
                end
            end
            if (i_cmd.meas_add) begin
                if (o_stat.last_sample) begin
                    r_sum[i_channel]   <= '0;
                    r_tally[i_channel] <= '0;
                end else begin
                    r_sum[i_channel]   <= w_sum_new;
                    r_tally[i_channel] <= w_tally_inc[TALLY_W-1:0];
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // divider and result working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_load) begin
            r_ch  <= i_channel;
            r_acc <= w_sum_new;
        end
        if (i_cmd.mean_calc) begin
            r_nq <= w_mean_prod[MEAN_K+SMP_W-1:MEAN_K];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[SMP_W-1:0] : w_trial[SMP_W-1:0];
            r_nq  <= {r_nq[SMP_W-2:0], w_ge};
        end
        if (i_cmd.prep) begin
            r_mean <= r_nq;
            r_x    <= w_x;
            r_lo   <= w_lo;
            r_hi   <= w_hi;
            r_fb   <= w_fb;
        end
        if (i_cmd.mul) begin
            r_rem  <= w_prod[PROD_W-1:SMP_W];
            r_nq   <= w_prod[SMP_W-1:0];
            r_den  <= r_hi - r_lo;
            r_zero <= (r_hi <= r_lo) || (r_x <= r_lo);
            r_full <= (r_x >= r_hi);
        end
        if (i_cmd.out_load) begin
            r_o_axis <= r_ch;
            r_o_pos  <= w_map[SMP_W-1:SMP_W-POS_W];
            r_o_mean <= r_mean;
            r_o_fb   <= r_fb;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_axis          = r_o_axis;
    assign o_position      = r_o_pos;
    assign o_mean_raw      = r_o_mean;
    assign o_fallback_used = r_o_fb;

    // tallies always close before reaching the average length
    a_tally_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tally[0] < AVG_CNT[TALLY_W-1:0] || AVG_CNT[TALLY_W])
        && (r_tally[1] < AVG_CNT[TALLY_W-1:0] || AVG_CNT[TALLY_W]))
        else $error("sample tally overran the average length");

    // start request leaves both channels as an empty calibration
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_low[0] == FULL12 && r_high[0] == '0
        && r_low[1] == FULL12 && r_high[1] == '0 && r_sum[0] == '0 && r_sum[1] == '0))
        else $error("start request did not clear calibration state");

    // a loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_valid)
        else $error("loaded result not presented");

endmodule

[design/two_axis_min_max_calibrated_scaler.sv]
// ----------------------------------------------------------------------------
// two_axis_min_max_calibrated_scaler
// Min/max calibrated two-axis scaler: tracks per-channel bounds, averages
// measurement samples and maps the mean linearly onto a 10-bit position.
//
//   channel   handshake              payload
//   input     i_valid / o_stall      i_req_type, i_channel, i_sample
//   output    o_valid / i_stall      o_axis, o_position, o_mean_raw,
//                                    o_fallback_used
//   config    i_cfg_we               i_cfg_data (fallback half span)
//
// Start, calibration and non-final measurement beats leave the sequencer idle.
// A measurement that closes an average passes the accepting beat, a
// reciprocal-multiply mean step, bound select, scale, 12 steps of the
// radix-2 divider for the mapping, and a finish state that waits while the
// output register is full and stalled. The output register lets the next
// beat in while a result waits; a result is held there while i_stall is high.
// Synchronous active-low reset gives an empty calibration and a half span
// of 1500; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_axis_min_max_calibrated_scaler
    import mmscl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_req_type,
    input  logic              i_channel,
    input  logic [SMP_W-1:0]  i_sample,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_axis,
    output logic [POS_W-1:0]  o_position,
    output logic [SMP_W-1:0]  o_mean_raw,
    output logic              o_fallback_used,
    input  logic              i_cfg_we,
    input  logic [HALF_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    mmscl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    mmscl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_channel       (i_channel),
        .i_sample        (i_sample),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_axis          (o_axis),
        .o_position      (o_position),
        .o_mean_raw      (o_mean_raw),
        .o_fallback_used (o_fallback_used)
    );

endmodule
